// File: sv/trq_pkg.sv
// ----------------------------------------------------------------------------
// Trace ring package
// Sizes, opcodes, state encodings and the structs passed between the
// front end, the command queue and the back end of the trace ring.
// ----------------------------------------------------------------------------
package trq_pkg;

   // ring and read sizing
   localparam int RING_DEPTH  = 8192;
   localparam int MAX_READ    = 64;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int FILL_W      = $clog2(RING_DEPTH + 1);
   localparam int LEN_W       = $clog2(MAX_READ + 1);

   // field widths
   localparam int SEQ_W       = 64;
   localparam int BYTE_W      = 8;
   localparam int OP_W        = 2;
   localparam int LIMIT_W     = 7;

   // read command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } trq_op_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_OLDEST,
      F_CLAMP,
      F_COUNT,
      F_ISSUE
   } trq_front_state_type;

   typedef enum logic {
      B_IDLE,
      B_RUN
   } trq_back_state_type;

   // one read, fully resolved by the front end
   typedef struct packed {
      logic [SEQ_W-1:0] start_seq;
      logic [SEQ_W-1:0] resume_seq;
      logic [SEQ_W-1:0] head_seq;
      logic             dropped;
      logic [PTR_W-1:0] pos;
      logic [LEN_W-1:0] count;
   } trq_cmd_type;

   // one result beat
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              byte_valid;
      logic [SEQ_W-1:0]  start_seq;
      logic [SEQ_W-1:0]  resume_seq;
      logic [SEQ_W-1:0]  head_seq;
      logic              dropped;
      logic              last;
   } trq_result_type;

   // read-side activity seen by the front end
   typedef struct packed {
      logic queue_empty;
      logic back_idle;
   } trq_status_type;

endpackage

// File: sv/trq_req_if.sv
// ----------------------------------------------------------------------------
// Trace ring request channel
// Valid/ready channel carrying one request item per beat.
// ----------------------------------------------------------------------------
interface trq_req_if import trq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [BYTE_W-1:0]   data_byte;
   logic [SEQ_W-1:0]    since_seq;
   logic [LIMIT_W-1:0]  max_bytes;

   modport source (output valid, op, data_byte, since_seq, max_bytes, input ready);
   modport sink   (input valid, op, data_byte, since_seq, max_bytes, output ready);
endinterface

// File: sv/trq_rsp_if.sv
// ----------------------------------------------------------------------------
// Trace ring response channel
// Valid/ready channel carrying one result item per beat.
// ----------------------------------------------------------------------------
interface trq_rsp_if import trq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  byte_value;
   logic               byte_valid;
   logic [SEQ_W-1:0]   start_seq;
   logic [SEQ_W-1:0]   resume_seq;
   logic [SEQ_W-1:0]   head_seq;
   logic               dropped;
   logic               last;

   modport source (output valid, byte_value, byte_valid, start_seq, resume_seq, head_seq,
                   dropped, last, input ready);
   modport sink   (input valid, byte_value, byte_valid, start_seq, resume_seq, head_seq,
                   dropped, last, output ready);
endinterface

// File: sv/trq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module trq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: sv/trq_queue.sv
// ----------------------------------------------------------------------------
// Trace ring command queue
// Short FIFO of resolved read commands between the front and back ends.
// ----------------------------------------------------------------------------
module trq_queue import trq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  trq_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output trq_cmd_type pop_data,
   output logic        empty
);

   trq_cmd_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/trq_front.sv
// ----------------------------------------------------------------------------
// Trace ring front end
// Takes request beats, keeps the ring pointers, writes trace bytes into the
// ring and resolves each read into a command for the back end.
// ----------------------------------------------------------------------------
module trq_front import trq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   trq_req_if.sink           req_bus,
   input  trq_status_type    status,
   input  logic              cmd_full,
   output logic              cmd_push,
   output trq_cmd_type       cmd_data,
   output logic              ram_we,
   output logic [PTR_W-1:0]  ram_waddr,
   output logic [BYTE_W-1:0] ram_wdata
);

   trq_front_state_type state_ff, state_in;

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;

   logic [SEQ_W-1:0]  since_ff, since_in;
   logic [LEN_W-1:0]  limit_ff, limit_in;
   logic [SEQ_W-1:0]  oldest_ff, oldest_in;
   logic [PTR_W-1:0]  opos_ff, opos_in;
   logic [SEQ_W-1:0]  start_ff, start_in;
   logic              dropped_ff, dropped_in;
   logic [LEN_W-1:0]  avail_ff, avail_in;
   logic [PTR_W-1:0]  pos_ff, pos_in;

   logic              reads_quiet;
   logic              accept;
   logic [FILL_W:0]   wp_ext, fill_ext, opos_sum;
   logic [SEQ_W-1:0]  diff;
   logic [FILL_W-1:0] offset;
   logic [FILL_W:0]   pos_sum;

   // a write may only land once every pending read has been delivered
   assign reads_quiet   = status.queue_empty && status.back_idle;
   assign req_bus.ready = (state_ff == F_IDLE) &&
                          ((req_bus.op != OP_WRITE) || reads_quiet);
   assign accept        = req_bus.valid && req_bus.ready;

   // ring write port
   assign ram_we    = accept && (req_bus.op == OP_WRITE);
   assign ram_waddr = wp_ff;
   assign ram_wdata = req_bus.data_byte;

   // read resolution arithmetic, one step per state
   always_comb begin
      wp_ext   = (FILL_W + 1)'(wp_ff);
      fill_ext = (FILL_W + 1)'(fill_ff);
      opos_sum = (wp_ext >= fill_ext) ? wp_ext - fill_ext
                                      : wp_ext + (FILL_W + 1)'(RING_DEPTH) - fill_ext;
      diff     = seq_ff - start_ff;
      offset   = start_ff[FILL_W-1:0] - oldest_ff[FILL_W-1:0];
      pos_sum  = (FILL_W + 1)'(opos_ff) + (FILL_W + 1)'(offset);
      if (pos_sum >= (FILL_W + 1)'(RING_DEPTH)) begin
         pos_sum = pos_sum - (FILL_W + 1)'(RING_DEPTH);
      end
   end

   // next state, pointer updates and read step registers
   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      seq_in     = seq_ff;
      since_in   = since_ff;
      limit_in   = limit_ff;
      oldest_in  = oldest_ff;
      opos_in    = opos_ff;
      start_in   = start_ff;
      dropped_in = dropped_ff;
      avail_in   = avail_ff;
      pos_in     = pos_ff;
      cmd_push   = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               unique case (req_bus.op)
                  OP_WRITE: begin
                     wp_in  = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
                     seq_in = seq_ff + SEQ_W'(1);
                     if (fill_ff < FILL_W'(RING_DEPTH)) begin
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     wp_in   = '0;
                     fill_in = '0;
                     seq_in  = '0;
                  end
                  OP_READ: begin
                     since_in = req_bus.since_seq;
                     limit_in = (req_bus.max_bytes > LIMIT_W'(MAX_READ)) ?
                                LEN_W'(MAX_READ) : req_bus.max_bytes[LEN_W-1:0];
                     state_in = F_OLDEST;
                  end
                  default: begin
                     // unused opcode: no effect
                  end
               endcase
            end
         end
         F_OLDEST: begin
            oldest_in = (seq_ff > SEQ_W'(fill_ff)) ? seq_ff - SEQ_W'(fill_ff) : '0;
            opos_in   = opos_sum[PTR_W-1:0];
            state_in  = F_CLAMP;
         end
         F_CLAMP: begin
            dropped_in = (since_ff < oldest_ff);
            priority if (since_ff < oldest_ff) begin
               start_in = oldest_ff;
            end else if (since_ff > seq_ff) begin
               start_in = seq_ff;
            end else begin
               start_in = since_ff;
            end
            state_in = F_COUNT;
         end
         F_COUNT: begin
            avail_in = (diff > SEQ_W'(limit_ff)) ? limit_ff : diff[LEN_W-1:0];
            pos_in   = pos_sum[PTR_W-1:0];
            state_in = F_ISSUE;
         end
         F_ISSUE: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // resolved read command
   always_comb begin
      cmd_data.start_seq  = start_ff;
      cmd_data.resume_seq = start_ff + SEQ_W'(avail_ff);
      cmd_data.head_seq   = seq_ff;
      cmd_data.dropped    = dropped_ff;
      cmd_data.pos        = pos_ff;
      cmd_data.count      = avail_ff;
   end

   // control and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         wp_ff    <= '0;
         fill_ff  <= '0;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         seq_ff   <= seq_in;
      end
   end

   // read step registers
   always_ff @(posedge clock) begin
      since_ff   <= since_in;
      limit_ff   <= limit_in;
      oldest_ff  <= oldest_in;
      opos_ff    <= opos_in;
      start_ff   <= start_in;
      dropped_ff <= dropped_in;
      avail_ff   <= avail_in;
      pos_ff     <= pos_in;
   end

   // fill count saturates at the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RING_DEPTH))
      else $error("fill count above ring depth");

   // every accepted write advances the byte sequence by one
   a_write_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_bus.op == OP_WRITE)) |=> (seq_ff == $past(seq_ff) + SEQ_W'(1)))
      else $error("write did not advance sequence");

endmodule

// File: sv/trq_back.sv
// ----------------------------------------------------------------------------
// Trace ring back end
// Pops resolved reads, walks the ring through the RAM read port at one byte
// per cycle while its two-entry output stage has room, and buffers result beats there.
// ----------------------------------------------------------------------------
module trq_back import trq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  trq_cmd_type       cmd_data,
   output logic              cmd_pop,
   output logic              ram_re,
   output logic [PTR_W-1:0]  ram_raddr,
   input  logic [BYTE_W-1:0] ram_rdata,
   trq_rsp_if.source         rsp_bus,
   output logic              back_idle
);

   trq_back_state_type state_ff, state_in;

   trq_cmd_type       cur_ff, cur_in;
   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic              has_byte_ff, has_byte_in;

   // one beat in flight through the RAM read
   logic              fly_valid_ff, fly_valid_in;
   trq_result_type    fly_ff, fly_in;

   // output stage: slot0 drives the channel, slot1 is the skid entry
   trq_result_type    slot0_ff, slot0_in;
   trq_result_type    slot1_ff, slot1_in;
   logic [1:0]        occ_ff, occ_in;

   logic              push, pop, issue_ok;
   trq_result_type    push_data;
   logic [2:0]        level;

   assign pop      = (occ_ff != 2'd0) && rsp_bus.ready;
   assign push     = fly_valid_ff;
   assign level    = 3'(occ_ff) + 3'(fly_valid_ff) - 3'(pop);
   assign issue_ok = (level <= 3'd1);

   always_comb begin
      push_data            = fly_ff;
      push_data.byte_value = fly_ff.byte_valid ? ram_rdata : '0;
   end

   // read sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      has_byte_in  = has_byte_ff;
      cmd_pop      = 1'b0;
      ram_re       = 1'b0;
      fly_valid_in = 1'b0;
      fly_in       = fly_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop     = 1'b1;
               cur_in      = cmd_data;
               addr_in     = cmd_data.pos;
               has_byte_in = (cmd_data.count != '0);
               remain_in   = (cmd_data.count == '0) ? LEN_W'(1) : cmd_data.count;
               state_in    = B_RUN;
            end
         end
         B_RUN: begin
            if (issue_ok) begin
               ram_re            = has_byte_ff;
               fly_valid_in      = 1'b1;
               fly_in.byte_value = '0;
               fly_in.byte_valid = has_byte_ff;
               fly_in.start_seq  = cur_ff.start_seq;
               fly_in.resume_seq = cur_ff.resume_seq;
               fly_in.head_seq   = cur_ff.head_seq;
               fly_in.dropped    = cur_ff.dropped;
               fly_in.last       = (remain_ff == LEN_W'(1));
               addr_in   = (addr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : addr_ff + PTR_W'(1);
               remain_in = remain_ff - LEN_W'(1);
               if (remain_ff == LEN_W'(1)) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign ram_raddr = addr_ff;

   // output stage update; credits keep a push off a full stage
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      occ_in   = 2'(level);
      unique case (occ_ff)
         2'd0: begin
            if (push) begin
               slot0_in = push_data;
            end
         end
         2'd1: begin
            if (push && pop) begin
               slot0_in = push_data;
            end else if (push) begin
               slot1_in = push_data;
            end
         end
         2'd2: begin
            if (pop) begin
               slot0_in = slot1_ff;
            end
         end
         default: begin
            occ_in = 2'd0;
         end
      endcase
   end

   assign rsp_bus.valid      = (occ_ff != 2'd0);
   assign rsp_bus.byte_value = slot0_ff.byte_value;
   assign rsp_bus.byte_valid = slot0_ff.byte_valid;
   assign rsp_bus.start_seq  = slot0_ff.start_seq;
   assign rsp_bus.resume_seq = slot0_ff.resume_seq;
   assign rsp_bus.head_seq   = slot0_ff.head_seq;
   assign rsp_bus.dropped    = slot0_ff.dropped;
   assign rsp_bus.last       = slot0_ff.last;

   assign back_idle = (state_ff == B_IDLE) && !fly_valid_ff && (occ_ff == 2'd0);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         fly_valid_ff <= 1'b0;
         occ_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         fly_valid_ff <= fly_valid_in;
         occ_ff       <= occ_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      addr_ff     <= addr_in;
      remain_ff   <= remain_in;
      has_byte_ff <= has_byte_in;
      fly_ff      <= fly_in;
      slot0_ff    <= slot0_in;
      slot1_ff    <= slot1_in;
   end

   // buffered plus in-flight beats never exceed the output stage
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (3'(occ_ff) + 3'(fly_valid_ff)) <= 3'd2)
      else $error("output stage overrun");

   // an empty-read beat is always the only, and so the last, beat of its read
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.byte_valid) |-> (rsp_bus.last && (rsp_bus.byte_value == '0)))
      else $error("empty result not marked last");

endmodule

// File: sv/sequenced_overwrite_trace_ring.sv
// ----------------------------------------------------------------------------
// Sequenced overwriting trace ring
// Byte trace ring with a running sequence number and reads by sequence.
// ----------------------------------------------------------------------------
// A write beat is taken every cycle while no read is pending and stores one
// byte, overwriting the oldest byte once the ring is full; a clear beat resets
// the pointers at once. A read beat passes four front-end steps (oldest byte,
// start clamp, byte count, command issue) and is then queued for the back end,
// which streams its results through the ring RAM's single read port at one
// byte per cycle while its output stage has room, or gives one empty result.
// Up to two resolved reads wait in the queue, and clears and further reads are
// taken meanwhile; a write beat is held off until every pending read has been
// fully delivered. The ring RAM has no reset and no clearing pass.
module sequenced_overwrite_trace_ring import trq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   trq_req_if.sink    req_bus,
   trq_rsp_if.source  rsp_bus
);

   trq_status_type    status;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   trq_cmd_type       cmd_in_data, cmd_out_data;
   logic              ram_we, ram_re;
   logic [PTR_W-1:0]  ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;
   logic              back_idle;

   assign status.queue_empty = cmd_empty;
   assign status.back_idle   = back_idle;

   // request intake and pointer keeping
   trq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .status    (status),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   // resolved read commands
   trq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   // ring storage
   trq_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // result streaming
   trq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_bus   (rsp_bus),
      .back_idle (back_idle)
   );

endmodule
